/* design/tps_pkg.sv */
// Shared types, codes and constants of the turntable position sequencer.
package tps_pkg;

  localparam int TURN_W     = 23;
  localparam int ANGLE_W    = 9;
  localparam int UNIT_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  typedef logic [TURN_W-1:0]  turn_t;
  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [UNIT_W-1:0]  unit_t;

  localparam turn_t TURN_MAX = '1;

  // event kinds
  localparam logic [1:0] KIND_POLL = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_HOME = 2'd2;
  localparam logic [1:0] KIND_CAL  = 2'd3;

  // move command codes
  localparam logic [1:0] MOVE_NONE = 2'd0;
  localparam logic [1:0] MOVE_REL  = 2'd1;
  localparam logic [1:0] MOVE_ABS  = 2'd2;

  // driver enable codes
  localparam logic [1:0] DRV_KEEP = 2'd0;
  localparam logic [1:0] DRV_ON   = 2'd1;
  localparam logic [1:0] DRV_OFF  = 2'd2;

  // homing status
  localparam logic [1:0] HOMED_NONE = 2'd0;
  localparam logic [1:0] HOMED_OK   = 2'd1;
  localparam logic [1:0] HOMED_FAIL = 2'd2;

  // calibration phases
  localparam logic [1:0] CAL_START  = 2'd0;
  localparam logic [1:0] CAL_SEARCH = 2'd1;
  localparam logic [1:0] CAL_TURN   = 2'd2;
  localparam logic [1:0] CAL_RETURN = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRAVERSER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_PH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SANITY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TURN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIS_IDLE  = 3'd6;

  // reset values
  localparam angle_t RST_ANGLE     = 9'd45;
  localparam turn_t  RST_SANITY    = 23'd50000;
  localparam turn_t  RST_HOME_MIN  = 23'd50;
  localparam turn_t  RST_INIT_TURN = 23'd4096;

  localparam int    DEG_FULL  = 360;
  localparam int    DEG_HALF  = 180;
  localparam int    DEG_FALLB = 45;

  localparam unit_t RST_UNIT  = UNIT_W'(RST_INIT_TURN / DEG_FULL);
  localparam turn_t RST_START = TURN_W'(RST_UNIT * RST_ANGLE);
  localparam turn_t RST_STOP  = TURN_W'(RST_UNIT * (RST_ANGLE + DEG_HALF));

  // x/360 = (x>>3)/45, done as multiply by ceil(2^26/45); exact for x < 2^23
  localparam int          RECIP_SHIFT = 26;
  localparam logic [20:0] RECIP_45    = 21'd1491309;

  typedef struct packed {
    turn_t start;
    turn_t stop;
  } points_t;

  function automatic unit_t div360(input turn_t x);
    logic [19:0] y;
    logic [40:0] p;
    y = x[TURN_W-1:3];
    p = y * RECIP_45;
    return p[RECIP_SHIFT +: UNIT_W];
  endfunction

endpackage

/* design/tps_points.sv */
// Phase switch points: full turn / 360 scaled by the effective phase angle.
module tps_points (
  input  logic            clk,
  input  logic            rst_n,
  input  tps_pkg::turn_t  full_turn_nxt,
  input  tps_pkg::angle_t angle,
  output tps_pkg::points_t pts
);
  import tps_pkg::*;

  unit_t      unit_r;
  points_t    pts_r;
  logic [7:0] a_eff;
  angle_t     a_far;
  logic [UNIT_W+ANGLE_W-1:0] prod_start;
  logic [UNIT_W+ANGLE_W-1:0] prod_stop;

  // angles of a half turn or more fall back to the default
  assign a_eff = (angle >= ANGLE_W'(DEG_HALF)) ? 8'(DEG_FALLB) : angle[7:0];
  assign a_far = ANGLE_W'(a_eff) + ANGLE_W'(DEG_HALF);

  assign prod_start = unit_r * a_eff;
  assign prod_stop  = unit_r * a_far;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r       <= RST_UNIT;
      pts_r.start  <= RST_START;
      pts_r.stop   <= RST_STOP;
    end else begin
      unit_r       <= div360(full_turn_nxt);
      pts_r.start  <= prod_start[TURN_W-1:0];
      pts_r.stop   <= prod_stop[TURN_W-1:0];
    end
  end

  assign pts = pts_r;

endmodule

/* design/turntable_position_sequencer_top.sv */
// Top level of the turntable / traverser position sequencer.
//
// Events (poll, move, home, calibrate) arrive on the in_ channel with the
// sensor levels and stepper status; each event yields exactly one result
// transaction on the out_ channel with the stepper command and the status.
// A transaction moves when valid is high and stall is low.
// Throughput: one event per cycle while the receiver does not stall and no
// register write holds the input; all work for an event is one pass through
// the decision logic between the input and result registers.
// The output register and the input register stand between the two sides, so
// an event is taken while a result waits; a stalled receiver backs the input
// up only once both registers hold data.
// Registers are written on the cfg_ channel (always ready) while the block is
// idle (user's rule, not enforced). The input stalls in a write and the cycle
// after, as switch points settle (two registered steps after the turn count).
// Reset (rst_n low, synchronous) empties both registers, loads the register
// defaults, clears homing and calibration state and the relay phase.
module turntable_position_sequencer_top #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // event channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_kind,
  input  tps_pkg::turn_t                      in_target_steps,
  input  logic                                in_manual_phase,
  input  logic                                in_home_active,
  input  logic                                in_limit_active,
  input  logic                                in_motor_running,
  input  logic signed [POSITION_WIDTH-1:0]    in_motor_position,
  input  logic signed [POSITION_WIDTH-1:0]    in_motor_target,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_stop_motor,
  output logic                                out_set_position,
  output logic signed [POSITION_WIDTH-1:0]    out_position_value,
  output logic [1:0]                          out_move_kind,
  output logic signed [POSITION_WIDTH:0]      out_move_steps,
  output logic [1:0]                          out_drive_enable,
  output logic                                out_phase,
  output logic [1:0]                          out_homed_state,
  output logic                                out_busy_calibrating,
  output tps_pkg::turn_t                      out_turn_steps,
  output logic                                out_store_turn,
  output logic                                out_clear_store,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tps_pkg::*;

  localparam int PW = POSITION_WIDTH;
  localparam int TW = POSITION_WIDTH + 1;
  localparam int WW = (POSITION_WIDTH + 2 > 26) ? POSITION_WIDTH + 2 : 26;
  localparam logic signed [WW-1:0] TURN_MAX_W = WW'(TURN_MAX);

  // configuration registers
  logic   trav_r, auto_r, dis_idle_r;
  angle_t angle_r;
  turn_t  sanity_r, hmt_r;
  logic   settle_r;
  logic   cfg_wr;

  // sequencer state
  turn_t          last_pos_r, last_pos_nxt;
  logic [1:0]     homed_r, homed_nxt;
  logic [TW-1:0]  lct_r, lct_nxt;
  logic           cal_r, cal_nxt;
  logic [1:0]     cph_r, cph_nxt;
  turn_t          full_turn_r, full_turn_nxt;
  logic           relay_r, relay_nxt;
  points_t        pts;

  // input register
  logic                 s1_valid_r;
  logic [1:0]           s1_kind_r;
  turn_t                s1_steps_r;
  logic                 s1_manual_r, s1_home_r, s1_limit_r, s1_running_r;
  logic signed [PW-1:0] s1_pos_r, s1_mtgt_r;

  // result register
  logic                 out_valid_r;
  logic                 stop_r, setp_r, store_r, clr_r;
  logic signed [PW-1:0] pval_r;
  logic [1:0]           mkind_r, de_r;
  logic signed [TW-1:0] msteps_r;

  // result of the current event
  logic                 stop_nxt, setp_nxt, store_nxt, clr_nxt;
  logic signed [PW-1:0] pval_nxt;
  logic [1:0]           mkind_nxt, de_nxt;
  logic signed [TW-1:0] msteps_nxt;

  logic proc, in_acc;

  // wide signed views
  logic signed [WW-1:0] pos_w, mtgt_w, s_w, l_w, f_w, h_w, d_w, mv_w;
  logic signed [WW-1:0] sanity_w, hmt_w, mag_w;
  turn_t                mag_sat;
  logic                 tgt_reached, cal_done, auto_ph;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  assign proc     = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = settle_r | cfg_valid | (s1_valid_r & ~proc);
  assign in_acc   = in_valid & ~in_stall;

  assign pos_w    = WW'(s1_pos_r);
  assign mtgt_w   = WW'(s1_mtgt_r);
  assign s_w      = WW'(s1_steps_r);
  assign l_w      = WW'(last_pos_r);
  assign f_w      = WW'(full_turn_r);
  assign h_w      = WW'(full_turn_r >> 1);
  assign sanity_w = WW'(sanity_r);
  assign hmt_w    = WW'(hmt_r);
  assign d_w      = s_w - l_w;

  // shortest way round the ring, or straight on a traverser
  always_comb begin
    if (trav_r)          mv_w = l_w - s_w;
    else if (d_w > h_w)  mv_w = s_w - f_w - l_w;
    else if (d_w < -h_w) mv_w = f_w - l_w + s_w;
    else                 mv_w = d_w;
  end

  assign auto_ph = ~((s1_steps_r < pts.start) |
                     ((s1_steps_r <= full_turn_r) & (s1_steps_r >= pts.stop)));

  assign mag_w   = (pos_w < 0) ? -pos_w : pos_w;
  assign mag_sat = (mag_w > TURN_MAX_W) ? TURN_MAX : mag_w[TURN_W-1:0];

  assign tgt_reached = (TW'(mtgt_w) == lct_r);
  assign cal_done = trav_r ? (cph_r == CAL_RETURN && !s1_limit_r)
                           : (cph_r == CAL_TURN && s1_home_r && pos_w > hmt_w);

  always_comb begin
    stop_nxt      = 1'b0;
    setp_nxt      = 1'b0;
    pval_nxt      = '0;
    mkind_nxt     = MOVE_NONE;
    msteps_nxt    = '0;
    de_nxt        = DRV_KEEP;
    store_nxt     = 1'b0;
    clr_nxt       = 1'b0;
    last_pos_nxt  = last_pos_r;
    homed_nxt     = homed_r;
    lct_nxt       = lct_r;
    cal_nxt       = cal_r;
    cph_nxt       = cph_r;
    full_turn_nxt = full_turn_r;
    relay_nxt     = relay_r;

    if (cfg_wr && cfg_index == REG_INIT_TURN) full_turn_nxt = cfg_data[TURN_W-1:0];

    if (proc) begin
      unique case (s1_kind_r)
        KIND_HOME: begin
          homed_nxt = HOMED_NONE;
          lct_nxt   = TW'(sanity_r);
        end
        KIND_CAL: begin
          cal_nxt   = 1'b1;
          homed_nxt = HOMED_NONE;
          lct_nxt   = TW'(sanity_r);
          clr_nxt   = 1'b1;
        end
        KIND_MOVE: begin
          if (!cal_r && homed_r != HOMED_NONE && s1_steps_r != last_pos_r) begin
            relay_nxt    = auto_r ? auto_ph : s1_manual_r;
            last_pos_nxt = s1_steps_r;
            de_nxt       = DRV_ON;
            mkind_nxt    = MOVE_REL;
            msteps_nxt   = TW'(mv_w);
            lct_nxt      = TW'(pos_w + mv_w);
          end
        end
        KIND_POLL: begin
          if (homed_r == HOMED_NONE) begin
            relay_nxt = 1'b0;
            if (s1_home_r) begin
              stop_nxt     = 1'b1;
              if (dis_idle_r) de_nxt = DRV_OFF;
              setp_nxt     = 1'b1;
              last_pos_nxt = '0;
              homed_nxt    = HOMED_OK;
            end else if (!s1_running_r) begin
              if (tgt_reached) begin
                // search ran its full length without finding home
                setp_nxt     = 1'b1;
                last_pos_nxt = '0;
                homed_nxt    = HOMED_FAIL;
              end else begin
                de_nxt     = DRV_ON;
                mkind_nxt  = MOVE_REL;
                msteps_nxt = TW'(sanity_w);
                lct_nxt    = TW'(pos_w + sanity_w);
              end
            end
          end else if (cal_r) begin
            relay_nxt = 1'b0;
            if (cal_done) begin
              stop_nxt      = 1'b1;
              if (dis_idle_r) de_nxt = DRV_OFF;
              full_turn_nxt = mag_sat;
              cal_nxt       = 1'b0;
              cph_nxt       = CAL_START;
              store_nxt     = 1'b1;
              setp_nxt      = 1'b1;
              pval_nxt      = s1_pos_r;
              homed_nxt     = HOMED_NONE;
              lct_nxt       = TW'(sanity_r);
            end else if (trav_r && cph_r == CAL_TURN && s1_limit_r) begin
              stop_nxt     = 1'b1;
              setp_nxt     = 1'b1;
              pval_nxt     = s1_pos_r;
              mkind_nxt    = MOVE_ABS;
              last_pos_nxt = '0;
              cph_nxt      = CAL_RETURN;
            end else if (cph_r == CAL_SEARCH && last_pos_r == sanity_r && s1_home_r &&
                         (trav_r || pos_w > hmt_w)) begin
              stop_nxt     = 1'b1;
              setp_nxt     = 1'b1;
              cph_nxt      = CAL_TURN;
              de_nxt       = DRV_ON;
              mkind_nxt    = MOVE_ABS;
              msteps_nxt   = trav_r ? TW'(-sanity_w) : TW'(sanity_w);
              last_pos_nxt = sanity_r;
            end else if (cph_r == CAL_START && !s1_running_r && homed_r == HOMED_OK) begin
              cph_nxt = CAL_SEARCH;
              // a traverser already sitting on home skips the search move
              if (!(trav_r && s1_home_r)) begin
                de_nxt     = DRV_ON;
                mkind_nxt  = MOVE_ABS;
                msteps_nxt = TW'(sanity_w);
              end
              last_pos_nxt = sanity_r;
            end else if ((cph_r == CAL_SEARCH || cph_r == CAL_TURN) && !s1_running_r &&
                         pos_w == sanity_w) begin
              if (dis_idle_r) de_nxt = DRV_OFF;
              cal_nxt = 1'b0;
              cph_nxt = CAL_START;
            end
          end
        end
        default: ;
      endcase
    end
  end

  tps_points u_points (
    .clk          (clk),
    .rst_n        (rst_n),
    .full_turn_nxt(full_turn_nxt),
    .angle        (angle_r),
    .pts          (pts)
  );

  // configuration; the turn count reload goes straight into full_turn_nxt
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trav_r      <= 1'b0;
      auto_r      <= 1'b0;
      angle_r     <= RST_ANGLE;
      sanity_r    <= RST_SANITY;
      hmt_r       <= RST_HOME_MIN;
      dis_idle_r  <= 1'b0;
      settle_r    <= 1'b0;
    end else begin
      settle_r <= cfg_wr;
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_TRAVERSER: trav_r      <= cfg_data[0];
          REG_AUTO_PH:   auto_r      <= cfg_data[0];
          REG_ANGLE:     angle_r     <= cfg_data[ANGLE_W-1:0];
          REG_SANITY:    sanity_r    <= cfg_data[TURN_W-1:0];
          REG_HOME_MIN:  hmt_r       <= cfg_data[TURN_W-1:0];
          REG_DIS_IDLE:  dis_idle_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r  <= '0;
      homed_r     <= HOMED_NONE;
      lct_r       <= TW'(RST_SANITY);
      cal_r       <= 1'b0;
      cph_r       <= CAL_START;
      full_turn_r <= RST_INIT_TURN;
      relay_r     <= 1'b0;
    end else begin
      last_pos_r  <= last_pos_nxt;
      homed_r     <= homed_nxt;
      lct_r       <= lct_nxt;
      cal_r       <= cal_nxt;
      cph_r       <= cph_nxt;
      full_turn_r <= full_turn_nxt;
      relay_r     <= relay_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r    <= in_kind;
      s1_steps_r   <= in_target_steps;
      s1_manual_r  <= in_manual_phase;
      s1_home_r    <= in_home_active;
      s1_limit_r   <= in_limit_active;
      s1_running_r <= in_motor_running;
      s1_pos_r     <= in_motor_position;
      s1_mtgt_r    <= in_motor_target;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      stop_r   <= stop_nxt;
      setp_r   <= setp_nxt;
      pval_r   <= pval_nxt;
      mkind_r  <= mkind_nxt;
      msteps_r <= msteps_nxt;
      de_r     <= de_nxt;
      store_r  <= store_nxt;
      clr_r    <= clr_nxt;
    end
  end

  // status fields follow the state that the last result left behind
  assign out_valid            = out_valid_r;
  assign out_stop_motor       = stop_r;
  assign out_set_position     = setp_r;
  assign out_position_value   = pval_r;
  assign out_move_kind        = mkind_r;
  assign out_move_steps       = msteps_r;
  assign out_drive_enable     = de_r;
  assign out_phase            = relay_r;
  assign out_homed_state      = homed_r;
  assign out_busy_calibrating = cal_r;
  assign out_turn_steps       = full_turn_r;
  assign out_store_turn       = store_r;
  assign out_clear_store      = clr_r;

endmodule

/* design/tps_checker.sv */
// Port-level assertions for the position sequencer, bound to its top level.
module tps_checker #(
  parameter int POSITION_WIDTH = 24
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_set_position,
  input logic signed [POSITION_WIDTH-1:0] out_position_value,
  input logic [1:0]                       out_move_kind,
  input logic signed [POSITION_WIDTH:0]   out_move_steps,
  input logic [1:0]                       out_homed_state,
  input logic                             out_busy_calibrating,
  input logic                             out_store_turn,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);
  import tps_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid & ~out_stall;

  // the input stalls in the cycle after a write, as switch points settle
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_valid && cfg_ready |=> in_stall)
    else $error("input not stalled after configuration write");

  a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_move_kind == MOVE_NONE |-> out_move_steps == '0)
    else $error("move amount without a move command");

  a_no_setp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_set_position |-> out_position_value == '0)
    else $error("position value without set position");

  // a stored turn count only ends a calibration, which drops homing
  a_store_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_store_turn |-> !out_busy_calibrating && out_homed_state == HOMED_NONE)
    else $error("turn count stored outside calibration end");

endmodule

bind turntable_position_sequencer_top tps_checker #(
  .POSITION_WIDTH(POSITION_WIDTH)
) u_tps_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_set_position    (out_set_position),
  .out_position_value  (out_position_value),
  .out_move_kind       (out_move_kind),
  .out_move_steps      (out_move_steps),
  .out_homed_state     (out_homed_state),
  .out_busy_calibrating(out_busy_calibrating),
  .out_store_turn      (out_store_turn),
  .cfg_valid           (cfg_valid),
  .cfg_ready           (cfg_ready)
);

/* tb/tb_turntable_position_sequencer_top.sv */
// Self-checking testbench for the turntable position sequencer: directed plan, then random phases.
`timescale 1ns / 1ps

module tb_turntable_position_sequencer_top;
  import tps_pkg::*;

  localparam int POS_W           = 24;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int N_PHASES        = 8;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    logic [1:0]       kind;
    turn_t            tgt;
    logic             man;
    logic             home;
    logic             lim;
    logic             run;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] mtgt;
  } ev_t;

  typedef struct packed {
    logic             stop;
    logic             setp;
    logic [POS_W-1:0] pval;
    logic [1:0]       mkind;
    logic [POS_W:0]   msteps;
    logic [1:0]       de;
    logic             phase;
    logic [1:0]       homed;
    logic             busy;
    turn_t            turn;
    logic             store;
    logic             clr;
  } res_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    turn_t                val;
    ev_t                  ev;
    bit                   typed;
    res_t                 want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_kind;
  turn_t in_target_steps;
  logic in_manual_phase, in_home_active, in_limit_active, in_motor_running;
  logic signed [POS_W-1:0] in_motor_position, in_motor_target;
  logic out_valid, out_stall;
  logic out_stop_motor, out_set_position;
  logic signed [POS_W-1:0] out_position_value;
  logic [1:0] out_move_kind;
  logic signed [POS_W:0] out_move_steps;
  logic [1:0] out_drive_enable;
  logic out_phase;
  logic [1:0] out_homed_state;
  logic out_busy_calibrating;
  turn_t out_turn_steps;
  logic out_store_turn, out_clear_store;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  turntable_position_sequencer_top #(.POSITION_WIDTH(POS_W)) dut (.*);

  always #4 clk = ~clk;

  // mirror of the sequencer: registers and state
  bit         trav, autop, dis_idle;
  angle_t     angle;
  turn_t      sanity, hmin;
  turn_t      last_pos, turn, pt_start, pt_stop;
  logic [1:0] homed, cal_ph;
  bit         cal_busy, relay;
  logic [POS_W:0] cmd_target;

  res_t pending_results[$];
  row_t plan[$];
  res_t want;
  int   snd_idle_pct, stall_pct;
  int   n_fail, n_events, n_checked, n_cfg, n_moves, n_cals;
  int   dead_cycles;

  function automatic void update_points();
    longint a, unit;
    a = (angle >= DEG_HALF) ? DEG_FALLB : angle;
    unit = turn / DEG_FULL;
    pt_start = turn_t'(unit * a);
    pt_stop = turn_t'(unit * (a + DEG_HALF));
  endfunction

  function automatic void reset_sequencer();
    trav = 0; autop = 0; dis_idle = 0;
    angle = RST_ANGLE; sanity = RST_SANITY; hmin = RST_HOME_MIN;
    turn = RST_INIT_TURN;
    last_pos = '0; homed = HOMED_NONE; cmd_target = (POS_W+1)'(RST_SANITY);
    cal_busy = 0; cal_ph = CAL_START; relay = 0;
    update_points();
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input turn_t val);
    case (idx)
      REG_TRAVERSER: trav = val[0];
      REG_AUTO_PH:   autop = val[0];
      REG_ANGLE: begin
        angle = val[ANGLE_W-1:0];
        update_points();
      end
      REG_SANITY:    sanity = val;
      REG_HOME_MIN:  hmin = val;
      REG_INIT_TURN: begin
        turn = val;
        update_points();
      end
      REG_DIS_IDLE:  dis_idle = val[0];
      default: ;
    endcase
  endfunction

  // one event through the sequencer; returns the command and status it yields
  function automatic res_t advance_sequencer(input ev_t e);
    res_t r;
    longint p, mt, tgt_s, s, l, f, h, d, mv, mag, lsan, lmin;
    bit done;
    r = '0;
    p = $signed(e.pos);
    mt = $signed(e.mtgt);
    tgt_s = $signed(cmd_target);
    lsan = sanity;
    lmin = hmin;
    case (e.kind)
      KIND_HOME: begin
        homed = HOMED_NONE;
        cmd_target = (POS_W+1)'(lsan);
      end
      KIND_CAL: begin
        cal_busy = 1;
        homed = HOMED_NONE;
        cmd_target = (POS_W+1)'(lsan);
        r.clr = 1;
      end
      KIND_MOVE: begin
        if (!cal_busy && homed != HOMED_NONE && e.tgt != last_pos) begin
          s = e.tgt; l = last_pos; f = turn; h = turn / 2;
          d = s - l;
          // shortest way round the ring unless linear
          if (trav) mv = l - s;
          else if (d > h) mv = s - f - l;
          else if (d < -h) mv = f - l + s;
          else mv = d;
          if (autop)
            relay = !((e.tgt < pt_start) || (e.tgt <= turn && e.tgt >= pt_stop));
          else
            relay = e.man;
          last_pos = e.tgt;
          r.de = DRV_ON; r.mkind = MOVE_REL; r.msteps = (POS_W+1)'(mv);
          cmd_target = (POS_W+1)'(p + mv);
        end
      end
      default: begin
        if (homed == HOMED_NONE) begin
          relay = 0;
          if (e.home) begin
            r.stop = 1;
            if (dis_idle) r.de = DRV_OFF;
            r.setp = 1;
            last_pos = '0;
            homed = HOMED_OK;
          end else if (!e.run) begin
            if (mt == tgt_s) begin
              // search move ran out without finding home
              r.setp = 1;
              last_pos = '0;
              homed = HOMED_FAIL;
            end else begin
              r.de = DRV_ON; r.mkind = MOVE_REL; r.msteps = (POS_W+1)'(lsan);
              cmd_target = (POS_W+1)'(p + lsan);
            end
          end
        end else if (cal_busy) begin
          done = trav ? (cal_ph == CAL_RETURN && !e.lim)
                      : (cal_ph == CAL_TURN && e.home && p > lmin);
          relay = 0;
          if (done) begin
            mag = (p < 0) ? -p : p;
            r.stop = 1;
            if (dis_idle) r.de = DRV_OFF;
            turn = (mag > TURN_MAX) ? TURN_MAX : turn_t'(mag);
            update_points();
            cal_busy = 0; cal_ph = CAL_START;
            r.store = 1; r.setp = 1; r.pval = POS_W'(p);
            homed = HOMED_NONE;
            cmd_target = (POS_W+1)'(lsan);
          end else if (trav && cal_ph == CAL_TURN && e.lim) begin
            r.stop = 1; r.setp = 1; r.pval = POS_W'(p);
            r.mkind = MOVE_ABS; r.msteps = '0;
            last_pos = '0;
            cal_ph = CAL_RETURN;
          end else if (cal_ph == CAL_SEARCH && last_pos == sanity && e.home &&
                       (trav || p > lmin)) begin
            r.stop = 1; r.setp = 1;
            cal_ph = CAL_TURN;
            r.de = DRV_ON; r.mkind = MOVE_ABS;
            r.msteps = trav ? (POS_W+1)'(-lsan) : (POS_W+1)'(lsan);
            last_pos = sanity;
          end else if (cal_ph == CAL_START && !e.run && homed == HOMED_OK) begin
            cal_ph = CAL_SEARCH;
            if (!(trav && e.home)) begin
              r.de = DRV_ON; r.mkind = MOVE_ABS; r.msteps = (POS_W+1)'(lsan);
            end
            last_pos = sanity;
          end else if ((cal_ph == CAL_SEARCH || cal_ph == CAL_TURN) && !e.run && p == lsan) begin
            // search hit the sanity limit: give up
            if (dis_idle) r.de = DRV_OFF;
            cal_busy = 0; cal_ph = CAL_START;
          end
        end
      end
    endcase
    r.phase = relay;
    r.homed = homed;
    r.busy = cal_busy;
    r.turn = turn;
    return r;
  endfunction

  // random event shaped by the current state so sequences get deep
  function automatic ev_t make_event();
    ev_t e;
    int pick;
    longint lmin;
    e = '0;
    lmin = hmin;
    pick = $urandom_range(0, 99);
    if (cal_busy && homed != HOMED_NONE)
      e.kind = (pick < 86) ? KIND_POLL : (pick < 92) ? KIND_MOVE : (pick < 96) ? KIND_CAL
                                                                            : KIND_HOME;
    else if (homed == HOMED_NONE)
      e.kind = (pick < 75) ? KIND_POLL : (pick < 85) ? KIND_MOVE : (pick < 93) ? KIND_CAL
                                                                            : KIND_HOME;
    else
      e.kind = (pick < 65) ? KIND_MOVE : (pick < 85) ? KIND_POLL : (pick < 92) ? KIND_CAL
                                                                            : KIND_HOME;
    case ($urandom_range(0, 11))
      0:  e.tgt = turn_t'($urandom);
      1:  e.tgt = last_pos;
      2:  e.tgt = pt_start;
      3:  e.tgt = pt_start - 1;
      4:  e.tgt = pt_stop;
      5:  e.tgt = pt_stop - 1;
      6:  e.tgt = turn;
      7:  e.tgt = turn + 1;
      8:  e.tgt = last_pos + turn / 2;
      9:  e.tgt = last_pos + turn / 2 + 1;
      10: e.tgt = last_pos - turn / 2 - 1;
      default: e.tgt = $urandom_range(0, turn);
    endcase
    e.man = $urandom_range(0, 1);
    e.home = $urandom_range(0, 99) < (cal_busy ? 40 : 25);
    e.lim = $urandom_range(0, 99) < 35;
    e.run = $urandom_range(0, 99) < 35;
    case ($urandom_range(0, 9))
      0:       e.pos = POS_W'($urandom);
      1:       e.pos = POS_W'(sanity);
      2:       e.pos = $urandom_range(0, 1) ? 24'h800000 : 24'h7fffff;
      3, 4, 5: e.pos = POS_W'(lmin + 1 + $urandom_range(0, 3000));
      6:       e.pos = POS_W'(lmin);
      default: e.pos = POS_W'(longint'($urandom_range(0, 65000)) - 5000);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: e.mtgt = POS_W'(cmd_target);
      4:          e.mtgt = 24'h800000;
      5:          e.mtgt = 24'h7fffff;
      default:    e.mtgt = POS_W'($urandom);
    endcase
    return e;
  endfunction

  function automatic void add_ev(input logic [1:0] kind, input turn_t tgt, input logic man,
                                 input logic home, input logic lim, input logic run,
                                 input logic [POS_W-1:0] pos, input logic [POS_W-1:0] mtgt);
    row_t row;
    row = '{default: '0};
    row.ev = '{kind, tgt, man, home, lim, run, pos, mtgt};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input turn_t val);
    row_t row;
    row = '{default: '0};
    row.is_cfg = 1;
    row.idx = idx;
    row.val = val;
    plan.push_back(row);
  endfunction

  function automatic void typed_result(input res_t r);
    plan[plan.size()-1].typed = 1;
    plan[plan.size()-1].want = r;
  endfunction

  function automatic res_t status_only(input logic ph, input logic [1:0] hs, input logic busy,
                                       input turn_t ts);
    res_t r;
    r = '0;
    r.phase = ph; r.homed = hs; r.busy = busy; r.turn = ts;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] exp_v,
                                      input logic signed [31:0] got);
    if (exp_v !== got) begin
      $display("%0t mismatch %s: expected %0d, got %0d", $time, name, exp_v, got);
      n_fail++;
    end
  endfunction

  task automatic send_event(input ev_t e, input bit typed, input res_t typed_want);
    res_t r;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= e.kind;
    in_target_steps <= e.tgt;
    in_manual_phase <= e.man;
    in_home_active <= e.home;
    in_limit_active <= e.lim;
    in_motor_running <= e.run;
    in_motor_position <= e.pos;
    in_motor_target <= e.mtgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = advance_sequencer(e);
    if (typed) r = typed_want;
    pending_results.push_back(r);
    n_events++;
    if (r.mkind != MOVE_NONE) n_moves++;
    if (r.store) n_cals++;
    @(negedge clk);
  endtask

  // hold the sender until every pending result has come back
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input turn_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    n_cfg++;
    @(negedge clk);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t result transaction with nothing pending", $time);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("stop_motor", want.stop, out_stop_motor);
        check_field("set_position", want.setp, out_set_position);
        check_field("position_value", $signed(want.pval), out_position_value);
        check_field("move_kind", want.mkind, out_move_kind);
        check_field("move_steps", $signed(want.msteps), out_move_steps);
        check_field("drive_enable", want.de, out_drive_enable);
        check_field("phase", want.phase, out_phase);
        check_field("homed_state", want.homed, out_homed_state);
        check_field("busy_calibrating", want.busy, out_busy_calibrating);
        check_field("turn_steps", want.turn, out_turn_steps);
        check_field("store_turn", want.store, out_store_turn);
        check_field("clear_store", want.clr, out_clear_store);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      dead_cycles <= 0;
    else
      dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t no transaction for %0d cycles", $time, dead_cycles);
      $display("tb_turntable_position_sequencer_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    res_t r;
    int k;
    bit v_trav, v_auto, v_dis;
    angle_t v_ang;
    turn_t v_san, v_min, v_turn;

    rst_n = 1'b0;
    in_valid = 1'b0; in_kind = KIND_POLL; in_target_steps = '0; in_manual_phase = 1'b0;
    in_home_active = 1'b0; in_limit_active = 1'b0; in_motor_running = 1'b0;
    in_motor_position = '0; in_motor_target = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_TRAVERSER; cfg_data = '0;
    snd_idle_pct = 0; stall_pct = 0;
    n_fail = 0; n_events = 0; n_checked = 0; n_cfg = 0; n_moves = 0; n_cals = 0;
    dead_cycles = 0;
    reset_sequencer();

    // directed plan, from the reset defaults
    add_ev(KIND_POLL, 0, 0, 0, 0, 1, 0, 0);
    typed_result(status_only(0, HOMED_NONE, 0, RST_INIT_TURN));
    add_ev(KIND_MOVE, TURN_MAX, 1, 0, 0, 0, 0, 0);          // not homed: ignored
    typed_result(status_only(0, HOMED_NONE, 0, RST_INIT_TURN));
    add_ev(KIND_POLL, 0, 0, 0, 0, 0, 0, 0);                 // homing search move
    r = status_only(0, HOMED_NONE, 0, RST_INIT_TURN);
    r.de = DRV_ON; r.mkind = MOVE_REL; r.msteps = (POS_W+1)'(RST_SANITY);
    typed_result(r);
    add_ev(KIND_POLL, 0, 0, 0, 0, 0, 0, POS_W'(RST_SANITY)); // search ran out
    r = status_only(0, HOMED_FAIL, 0, RST_INIT_TURN);
    r.setp = 1;
    typed_result(r);
    add_ev(KIND_MOVE, 1000, 1, 0, 0, 0, 0, 0);
    add_ev(KIND_HOME, 0, 0, 0, 0, 0, 0, 0);
    add_ev(KIND_POLL, 0, 0, 1, 0, 1, 0, 0);                 // home found
    r = status_only(0, HOMED_OK, 0, RST_INIT_TURN);
    r.stop = 1; r.setp = 1;
    typed_result(r);
    add_ev(KIND_MOVE, TURN_MAX, 0, 0, 0, 0, 0, 0);
    add_ev(KIND_MOVE, 0, 1, 0, 0, 0, 0, 0);
    add_ev(KIND_MOVE, 0, 1, 0, 0, 0, 0, 0);                 // already there
    add_ev(KIND_MOVE, 3000, 1, 0, 0, 0, 0, 0);
    add_ev(KIND_MOVE, 100, 0, 1, 1, 1, 24'h800000, 24'h7fffff);
    add_ev(KIND_CAL, 0, 0, 0, 0, 0, 0, 0);
    add_ev(KIND_POLL, 0, 0, 1, 0, 1, 0, 0);
    add_ev(KIND_POLL, 0, 0, 0, 0, 0, 0, 0);
    add_ev(KIND_POLL, 0, 0, 1, 0, 1, 4000, 0);
    add_ev(KIND_POLL, 0, 0, 0, 0, 1, 2000, 24'h800000);
    add_ev(KIND_POLL, 0, 0, 1, 0, 1, 4200, 0);              // rotary calibration done
    add_cfg(REG_TRAVERSER, 1);
    add_ev(KIND_CAL, 0, 0, 0, 0, 0, 0, 0);
    add_ev(KIND_POLL, 0, 0, 1, 0, 1, 0, 0);
    add_ev(KIND_POLL, 0, 0, 1, 0, 0, 0, 0);
    add_ev(KIND_POLL, 0, 0, 1, 0, 1, 0, 0);
    add_ev(KIND_POLL, 0, 0, 0, 1, 1, -30000, 0);            // limit reached
    add_cfg(REG_TRAVERSER, 0);
    add_ev(KIND_POLL, 0, 0, 0, 0, 0, 0, 0);                 // return phase on rotary: waits
    add_cfg(REG_TRAVERSER, 1);
    add_ev(KIND_POLL, 0, 0, 0, 0, 0, 24'h800000, 0);        // count saturates
    add_cfg(REG_TRAVERSER, 0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain(4);
        write_reg(plan[i].idx, plan[i].val);
        cfg_valid <= 1'b0;
      end else begin
        send_event(plan[i].ev, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain(4);
      v_trav = $urandom_range(0, 1);
      v_auto = $urandom_range(0, 1);
      v_dis = $urandom_range(0, 1);
      v_ang = $urandom_range(0, 359);
      v_san = $urandom_range(200, 60000);
      v_min = $urandom_range(0, 3000);
      v_turn = $urandom_range(360, 20000);
      if (ph == 1) begin
        v_trav = 0; v_auto = 0; v_ang = 0; v_san = 1; v_min = 0; v_turn = 0; v_dis = 0;
      end else if (ph == 2) begin
        v_trav = 1; v_auto = 1; v_ang = 359; v_dis = 1;
        v_san = TURN_MAX; v_min = TURN_MAX; v_turn = TURN_MAX;
      end else if (ph == 3) begin
        v_ang = DEG_HALF;
      end
      write_reg(REG_TRAVERSER, v_trav);
      write_reg(REG_AUTO_PH, v_auto);
      write_reg(REG_ANGLE, v_ang);
      write_reg(REG_SANITY, v_san);
      write_reg(REG_HOME_MIN, v_min);
      write_reg(REG_INIT_TURN, v_turn);
      write_reg(REG_DIS_IDLE, v_dis);
      cfg_valid <= 1'b0;
      case (ph % 4)
        0: begin snd_idle_pct = 0;  stall_pct = 0;  end
        1: begin snd_idle_pct = 65; stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  stall_pct = 65; end
        default: begin snd_idle_pct = 14; stall_pct = 14; end
      endcase
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2) drain(1);
        send_event(make_event(), 0, '0);
      end
    end

    snd_idle_pct = 0;
    stall_pct = 0;
    drain(8);
    $display("covered %0d events and %0d checked results over %0d register writes",
             n_events, n_checked, n_cfg);
    $display("stepper moves commanded: %0d, calibrations completed: %0d", n_moves, n_cals);
    if (n_fail == 0) begin
      $display("tb_turntable_position_sequencer_top OK");
    end else begin
      $display("tb_turntable_position_sequencer_top NOT OK");
    end
    $finish;
  end

endmodule
